// ===== rtl/block_placement_over_valid_procs_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block placement design.
// Expects a clock i_clk and an active-low reset i_rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef BLOCK_PLACEMENT_OVER_VALID_PROCS_MACROS_SVH
`define BLOCK_PLACEMENT_OVER_VALID_PROCS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPOV_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpov assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BPOV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpov assertion failed");

`endif

// ===== rtl/bpov_pkg.sv =====
// ----------------------------------------------------------------------------
// bpov_pkg
// Shared types and codes of the block placement pipeline.
// ----------------------------------------------------------------------------
package bpov_pkg;

    // Byte addresses of the configuration registers.
    localparam logic [3:0] REG_MASK_ADDR  = 4'd0;
    localparam logic [3:0] REG_COUNT_ADDR = 4'd8;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_MOVABLE = 2'd1,
        ST_NO_PROC     = 2'd2,
        ST_RANGE       = 2'd3
    } t_status;

    // Values derived from the configuration after each register write.
    typedef struct packed {
        logic        busy;
        logic [6:0]  valid_count;
        logic [30:0] share_floor;
        logic [5:0]  extra_count;
        logic [31:0] mark_index;
    } t_derived;

    // One slot of the pipelined divider.
    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [5:0]  offset;
        logic [30:0] rem;
        logic [30:0] num;
        logic [31:0] den;
    } t_div;

endpackage

// ===== rtl/bpov_div_stage.sv =====
// ----------------------------------------------------------------------------
// bpov_div_stage
// One restoring division step: resolves quotient bit BIT and registers it.
// ----------------------------------------------------------------------------
module bpov_div_stage #(
    parameter int BIT = 30
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  bpov_pkg::t_div  i_slot,
    output bpov_pkg::t_div  o_slot
);

    bpov_pkg::t_div r_slot;
    bpov_pkg::t_div n_slot;
    logic [31:0]    w_trial;
    logic [30:0]    w_diff;
    logic           w_ge;

    always_comb begin
        w_trial = {i_slot.rem, i_slot.num[BIT]};
        w_ge    = (w_trial >= i_slot.den);
        w_diff  = 31'(w_trial - i_slot.den);
        n_slot  = i_slot;
        n_slot.rem = w_ge ? w_diff : w_trial[30:0];
        // The consumed dividend bit is replaced by the quotient bit.
        n_slot.num[BIT] = w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else if (i_adv) begin
            r_slot.valid <= n_slot.valid;
        end
        if (i_adv) begin
            r_slot.status <= n_slot.status;
            r_slot.offset <= n_slot.offset;
            r_slot.rem    <= n_slot.rem;
            r_slot.num    <= n_slot.num;
            r_slot.den    <= n_slot.den;
        end
    end

    assign o_slot = r_slot;

endmodule

// ===== rtl/bpov_derive.sv =====
// ----------------------------------------------------------------------------
// bpov_derive
// Sweeps the availability mask into a block-to-processor table, then divides
// the object count by the processor count and forms the mark index.
// ----------------------------------------------------------------------------
module bpov_derive #(
    parameter  int MAX_PROCS = 64,
    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [63:0]              i_mask,
    input  logic [30:0]              i_count,
    input  logic                     i_rd_en,
    input  logic [PW-1:0]            i_rd_addr,
    output logic [5:0]               o_rd_data,
    output bpov_pkg::t_derived       o_drv
);

    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(MAX_PROCS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SWEEP = 4'b0010,
        S_DIV   = 4'b0100,
        S_MARK  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [PW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [6:0]      r_vcount, n_vcount;
    logic [6:0]      r_rem, n_rem;
    logic [30:0]     r_num, n_num;
    logic [4:0]      r_bit, n_bit;
    logic [30:0]     r_share, n_share;
    logic [5:0]      r_extra, n_extra;
    logic [31:0]     r_mark, n_mark;
    logic [PW-1:0]   r_table [MAX_PROCS];
    logic [PW-1:0]   r_rd;
    logic [MAX_PROCS-1:0] w_usable;
    logic            w_wr;
    logic [7:0]      w_trial;
    logic [6:0]      w_diff;
    logic            w_ge;

    assign w_usable = i_mask[MAX_PROCS-1:0];
    assign w_trial  = {r_rem, r_num[r_bit]};
    assign w_ge     = (w_trial >= {1'b0, r_vcount});
    assign w_diff   = 7'(w_trial - {1'b0, r_vcount});
    assign w_wr     = (r_state == S_SWEEP) && w_usable[r_pos];

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_vcount = r_vcount;
        n_rem    = r_rem;
        n_num    = r_num;
        n_bit    = r_bit;
        n_share  = r_share;
        n_extra  = r_extra;
        n_mark   = r_mark;
        if (i_start) begin
            n_state = S_SWEEP;
            n_pos   = '0;
            n_cnt   = '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                end
                S_SWEEP: begin
                    if (w_usable[r_pos]) begin
                        n_cnt = r_cnt + CW'(1);
                    end
                    n_pos = r_pos + PW'(1);
                    if (r_pos == LAST_POS) begin
                        n_vcount = 7'(n_cnt);
                        n_rem    = '0;
                        n_num    = i_count;
                        n_bit    = 5'd30;
                        if (n_cnt == '0) begin
                            n_share = '0;
                            n_extra = '0;
                            n_mark  = '0;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    n_rem        = w_ge ? w_diff : w_trial[6:0];
                    n_num[r_bit] = w_ge;
                    n_bit        = r_bit - 5'd1;
                    if (r_bit == 5'd0) begin
                        n_state = S_MARK;
                    end
                end
                S_MARK: begin
                    n_share = r_num;
                    n_extra = r_rem[5:0];
                    n_mark  = 32'({26'd0, r_rem[5:0]} * ({1'b0, r_num} + 32'd1));
                    n_state = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_vcount <= '0;
            r_rem    <= '0;
            r_num    <= '0;
            r_bit    <= '0;
            r_share  <= '0;
            r_extra  <= '0;
            r_mark   <= '0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            r_vcount <= n_vcount;
            r_rem    <= n_rem;
            r_num    <= n_num;
            r_bit    <= n_bit;
            r_share  <= n_share;
            r_extra  <= n_extra;
            r_mark   <= n_mark;
        end
    end

    // Entry k of the table holds the position of the (k+1)-th set mask bit.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_table[r_cnt[PW-1:0]] <= r_pos;
        end
        if (i_rd_en) begin
            r_rd <= r_table[i_rd_addr];
        end
    end

    assign o_rd_data         = 6'(r_rd);
    assign o_drv.busy        = (r_state != S_IDLE);
    assign o_drv.valid_count = r_vcount;
    assign o_drv.share_floor = r_share;
    assign o_drv.extra_count = r_extra;
    assign o_drv.mark_index  = r_mark;

endmodule

// ===== rtl/block_placement_over_valid_procs.sv =====
// Stages from input transaction to result: entry, 31 divider steps, clamp,
// table read. Throughput: one transaction per cycle while input is not stalled.
// A register write recomputes the derived values (mask sweep, then, with any
// processor set, 31-step division and mark multiply); input is stalled meanwhile.
// Reset (synchronous, active low) clears registers and derived values to zero.
// ----------------------------------------------------------------------------
// block_placement_over_valid_procs
// Maps object indices to processors in contiguous blocks over the available
// processors, through a fully pipelined restoring divider.
// ----------------------------------------------------------------------------
`include "block_placement_over_valid_procs_macros.svh"

module block_placement_over_valid_procs #(
    parameter int MAX_PROCS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [30:0] i_array_index,
    input  logic        i_movable,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_dest_proc,
    output logic [1:0]  o_status
);

    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    logic [63:0]          r_mask;
    logic [30:0]          r_count;
    logic                 w_wr;
    bpov_pkg::t_derived   w_drv;
    logic                 w_adv;
    logic                 w_accept;
    bpov_pkg::t_div       n_entry;
    bpov_pkg::t_div       r_entry;
    bpov_pkg::t_div       w_div [32];
    logic                 w_lower;
    logic                 r_cl_valid;
    bpov_pkg::t_status    r_cl_status;
    logic [PW-1:0]        r_cl_addr;
    logic [31:0]          w_block;
    logic [6:0]           w_clamped;
    logic                 r_out_valid;
    bpov_pkg::t_status    r_out_status;
    logic [5:0]           w_rd_data;

    // Configuration port.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = (paddr == bpov_pkg::REG_COUNT_ADDR) ? {33'd0, r_count} : r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_count <= '0;
        end else if (w_wr) begin
            if (paddr == bpov_pkg::REG_COUNT_ADDR) begin
                r_count <= pwdata[30:0];
            end else if (paddr == bpov_pkg::REG_MASK_ADDR) begin
                r_mask <= pwdata;
            end
        end
    end

    bpov_derive #(
        .MAX_PROCS (MAX_PROCS)
    ) u_derive (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_wr),
        .i_mask    (r_mask),
        .i_count   (r_count),
        .i_rd_en   (w_adv),
        .i_rd_addr (r_cl_addr),
        .o_rd_data (w_rd_data),
        .o_drv     (w_drv)
    );

    // The whole pipeline holds while a finished result is stalled.
    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = w_drv.busy || !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Entry: classify the transaction and pick the dividend and divisor.
    always_comb begin
        w_lower        = ({1'b0, i_array_index} < w_drv.mark_index);
        n_entry.valid  = w_accept;
        n_entry.rem    = '0;
        if (w_lower) begin
            n_entry.num    = i_array_index;
            n_entry.den    = {1'b0, w_drv.share_floor} + 32'd1;
            n_entry.offset = '0;
        end else begin
            n_entry.num    = 31'({1'b0, i_array_index} - w_drv.mark_index);
            n_entry.den    = {1'b0, w_drv.share_floor};
            n_entry.offset = w_drv.extra_count;
        end
        priority if (w_drv.valid_count == '0) begin
            n_entry.status = bpov_pkg::ST_NO_PROC;
        end else if (!i_movable) begin
            n_entry.status = bpov_pkg::ST_NOT_MOVABLE;
        end else if (i_array_index >= r_count) begin
            n_entry.status = bpov_pkg::ST_RANGE;
        end else if (!w_lower && (w_drv.share_floor == '0)) begin
            n_entry.status = bpov_pkg::ST_RANGE;
        end else begin
            n_entry.status = bpov_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (w_adv) begin
            r_entry.valid <= n_entry.valid;
        end
        if (w_adv) begin
            r_entry.status <= n_entry.status;
            r_entry.offset <= n_entry.offset;
            r_entry.rem    <= n_entry.rem;
            r_entry.num    <= n_entry.num;
            r_entry.den    <= n_entry.den;
        end
    end

    assign w_div[0] = r_entry;

    for (genvar k = 0; k < 31; k++) begin : g_div
        bpov_div_stage #(
            .BIT (30 - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_slot  (w_div[k]),
            .o_slot  (w_div[k+1])
        );
    end

    // Clamp the block number to the last available processor.
    always_comb begin
        w_block = {1'b0, w_div[31].num} + 32'(w_div[31].offset);
        if (w_block >= 32'(w_drv.valid_count)) begin
            w_clamped = w_drv.valid_count - 7'd1;
        end else begin
            w_clamped = w_block[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_cl_valid  <= w_div[31].valid;
            r_out_valid <= r_cl_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cl_status  <= w_div[31].status;
            r_cl_addr    <= w_clamped[PW-1:0];
            r_out_status <= r_cl_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_dest_proc = (r_out_status == bpov_pkg::ST_OK) ? w_rd_data : 6'd0;

    `BPOV_ASSERT_SAME(a_busy_stalls, w_drv.busy, o_in_stall)
    `BPOV_ASSERT_NEXT(a_write_starts_derive, w_wr, w_drv.busy)
    `BPOV_ASSERT_SAME(a_dest_zero, o_out_valid && (o_status != bpov_pkg::ST_OK), o_dest_proc == 6'd0)
    `BPOV_ASSERT_SAME(a_no_proc_status, o_out_valid && (w_drv.valid_count == 7'd0), o_status == bpov_pkg::ST_NO_PROC)

endmodule

// ===== bench/tb_block_placement_over_valid_procs.sv =====
// ----------------------------------------------------------------------------
// Block placement testbench
// Streams object indices through the block under several mask and object
// count settings, predicts each processor assignment, and checks every result
// in order while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_block_placement_over_valid_procs;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [30:0] array_index;
        logic        movable;
    } t_object;

    typedef struct packed {
        logic [5:0]        dest_proc;
        bpov_pkg::t_status status;
    } t_placement;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [30:0] i_array_index = '0;
    logic        i_movable = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [5:0]  o_dest_proc;
    logic [1:0]  o_status;

    block_placement_over_valid_procs dut (.*);

    always #4 i_clk = ~i_clk;

    // Copy of the configuration and the derived values.
    logic [63:0] avail_mask;
    logic [30:0] obj_count;
    logic [6:0]  proc_count;
    logic [30:0] floor_share;
    logic [5:0]  extra_blocks;
    logic [31:0] first_plain_index;

    t_object    pending_objects[$];
    t_placement expected_placements[$];
    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  failed = 0;
    bit  in_taken = 0;
    int  quiet_cycles = 0;

    function automatic void recompute_shares();
        proc_count = '0;
        for (int p = 0; p < 64; p++) proc_count = proc_count + 7'(avail_mask[p]);
        if (proc_count == 0) begin
            floor_share = '0;
            extra_blocks = '0;
            first_plain_index = '0;
        end else begin
            floor_share = obj_count / proc_count;
            extra_blocks = 6'(obj_count % proc_count);
            first_plain_index = extra_blocks * ({1'b0, floor_share} + 32'd1);
        end
    endfunction

    function automatic t_placement place_object(t_object obj);
        t_placement res;
        logic [31:0] blk;
        int seen;
        res.dest_proc = '0;
        res.status = bpov_pkg::ST_OK;
        blk = '0;
        seen = 0;
        if (proc_count == 0) res.status = bpov_pkg::ST_NO_PROC;
        else if (!obj.movable) res.status = bpov_pkg::ST_NOT_MOVABLE;
        else if (obj.array_index >= obj_count) res.status = bpov_pkg::ST_RANGE;
        else begin
            if (obj.array_index < first_plain_index)
                blk = obj.array_index / ({1'b0, floor_share} + 32'd1);
            else if (floor_share == 0) res.status = bpov_pkg::ST_RANGE;
            else blk = (obj.array_index - first_plain_index) / floor_share + extra_blocks;
            if (res.status == bpov_pkg::ST_OK) begin
                if (blk >= proc_count) blk = proc_count - 1;
                for (int p = 0; p < 64; p++) begin
                    if (avail_mask[p]) begin
                        if (seen == blk) res.dest_proc = p[5:0];
                        seen++;
                    end
                end
            end
        end
        return res;
    endfunction

    // Driver: presents queued objects, changing inputs on the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_taken) begin
                // Hold the stalled transaction.
            end else if (pending_objects.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_array_index <= pending_objects[0].array_index;
                i_movable <= pending_objects[0].movable;
                void'(pending_objects.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: predicts on accepted inputs and checks accepted results.
    always @(posedge i_clk) begin
        t_placement got;
        t_placement want;
        bit active;
        if (i_rst_n) begin
            active = 1'b0;
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                expected_placements.push_back(place_object({i_array_index, i_movable}));
                active = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                active = 1'b1;
                got.dest_proc = o_dest_proc;
                got.status = bpov_pkg::t_status'(o_status);
                if (expected_placements.size() == 0) begin
                    $display("%0t: unexpected result dest=%0d status=%0d",
                             $time, o_dest_proc, o_status);
                    failed = 1;
                end else begin
                    want = expected_placements.pop_front();
                    if (got.dest_proc !== want.dest_proc)
                        $display("%0t: dest_proc expected %0d actual %0d",
                                 $time, want.dest_proc, got.dest_proc);
                    if (got.status !== want.status)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    if (got !== want) failed = 1;
                end
            end
            quiet_cycles <= active ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        pwrite <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == bpov_pkg::REG_MASK_ADDR) avail_mask = value;
        else obj_count = value[30:0];
        recompute_shares();
    endtask

    task automatic configure(input logic [63:0] mask, input logic [30:0] count);
        write_reg(bpov_pkg::REG_MASK_ADDR, mask);
        write_reg(bpov_pkg::REG_COUNT_ADDR, {33'd0, count});
    endtask

    // Waits until every queued transaction has been sent and answered.
    task automatic drain();
        while (pending_objects.size() > 0 || i_in_valid || expected_placements.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [30:0] pick_index();
        logic [30:0] v;
        case ($urandom_range(3))
            0: v = 31'($urandom);
            1: v = (obj_count > 0) ? 31'($urandom_range(obj_count - 1)) : '0;
            2: v = 31'(obj_count + $urandom_range(2) - 1);
            default: v = 31'($urandom_range(first_plain_index + 2));
        endcase
        return v;
    endfunction

    function automatic logic [63:0] random_mask();
        logic [63:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(3))
            0: m = m & {$urandom, $urandom};
            1: m = 64'd1 << $urandom_range(63);
            default: ;
        endcase
        return m;
    endfunction

    initial begin
        logic [30:0] counts[4];
        avail_mask = '0;
        obj_count = '0;
        recompute_shares();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state gives no processor, then the extremes.
        pending_objects.push_back({31'd0, 1'b1});
        pending_objects.push_back({31'h7fffffff, 1'b0});
        drain();
        configure(64'hffffffffffffffff, 31'h7fffffff);
        pending_objects.push_back({31'd0, 1'b1});
        pending_objects.push_back({31'h7ffffffe, 1'b1});
        pending_objects.push_back({31'h7fffffff, 1'b1});
        pending_objects.push_back({31'h55555555, 1'b0});
        pending_objects.push_back({31'h2aaaaaaa, 1'b1});
        drain();
        // Fewer objects than processors: zero share.
        configure(64'h8000000000000001, 31'd1);
        for (int i = 0; i < 4; i++) pending_objects.push_back({i[30:0], 1'b1});
        drain();
        configure(64'hf0f0, 31'd10);
        for (int i = 0; i < 12; i++) pending_objects.push_back({i[30:0], 1'b1});
        drain();
        configure(64'd0, 31'd5);
        pending_objects.push_back({31'd2, 1'b1});
        drain();

        // Random phases across idling profiles and settings.
        for (int ph = 0; ph < 20; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            counts[0] = 31'($urandom_range(200));
            counts[1] = 31'($urandom);
            counts[2] = 31'($urandom_range(63));
            counts[3] = 31'h7fffffff;
            configure(random_mask(), counts[$urandom_range(3)]);
            for (int i = 0; i < 52; i++)
                pending_objects.push_back({pick_index(), ($urandom_range(9) != 0)});
            drain();
        end

        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bpov_pkg.sv
rtl/bpov_div_stage.sv
rtl/bpov_derive.sv
rtl/block_placement_over_valid_procs.sv
bench/tb_block_placement_over_valid_procs.sv
